// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/omr_pkg.sv -----
package omr_pkg;

  localparam int SLOTS     = 8;
  localparam int MSG_BYTES = 256;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(MSG_BYTES + 1);
  localparam int BOFF_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int DEPTH  = SLOTS * MSG_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_POP   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_OVERWR   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_data;
    logic [8:0] message_length;
    logic [2:0] tail_index;
    logic       is_empty;
  } out_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] message_length;
    logic [2:0] tail_index;
    logic       is_empty;
    logic       rd_ok;
  } meta_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/overwrite_oldest_message_ring_unit.sv -----
// A result passes the stage-1 register and the memory's read register, then the
// output register. One transaction per cycle while the output does not stall; the
// message store is a single-port write, single-port registered-read memory.
// Reset clears head, tail, the partial-message count and the pipeline valids;
// the message bytes and lengths hold no defined value until written.
module overwrite_oldest_message_ring_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  omr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output omr_pkg::out_item_t out_item
);

  logic                       in_accept;
  logic                       ram_we;
  logic [omr_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [omr_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_q;
  omr_pkg::meta_t             meta;

  assign in_accept = in_valid && !in_stall;

  omr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .meta      (meta)
  );

  omr_ram #(
    .WIDTH (8),
    .DEPTH (omr_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .q_r   (ram_q)
  );

  omr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .meta      (meta),
    .ram_q     (ram_q),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/omr_ram.sv -----
module omr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      q_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/omr_ctrl.sv -----
module omr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  omr_pkg::in_item_t           in_item,
  output logic                        ram_we,
  output logic [omr_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [omr_pkg::ADDR_W-1:0]  ram_raddr,
  output omr_pkg::meta_t              meta
);

  logic [omr_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic [omr_pkg::SLOT_W-1:0] tail_r, tail_nxt;
  logic [omr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [omr_pkg::CNT_W-1:0]  len_r [omr_pkg::SLOTS];

  logic [omr_pkg::SLOT_W-1:0] wslot;
  logic [omr_pkg::SLOT_W-1:0] oldest;
  logic [omr_pkg::CNT_W-1:0]  old_len;
  logic                       empty;
  logic                       room;
  logic                       len_we;

  assign empty   = (head_r == tail_r);
  assign wslot   = omr_pkg::next_slot(tail_r);
  assign oldest  = omr_pkg::next_slot(head_r);
  assign old_len = len_r[oldest];
  assign room    = (int'(cnt_r) < omr_pkg::MSG_BYTES);

  assign ram_wdata = in_item.data_byte;
  assign ram_waddr = omr_pkg::ADDR_W'(int'(wslot) * omr_pkg::MSG_BYTES
                     + int'(cnt_r[omr_pkg::BOFF_W-1:0]));
  assign ram_raddr = omr_pkg::ADDR_W'(int'(oldest) * omr_pkg::MSG_BYTES
                     + int'(in_item.byte_index) % omr_pkg::MSG_BYTES);

  always_comb begin
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    cnt_nxt             = cnt_r;
    ovf_nxt             = ovf_r;
    len_we              = 1'b0;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    meta.status         = omr_pkg::ST_OK;
    meta.message_length = '0;
    meta.rd_ok          = 1'b0;
    case (in_item.operation)
      omr_pkg::OP_WRITE: begin
        if (room) begin
          ram_we  = in_accept;
          cnt_nxt = cnt_r + omr_pkg::CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (in_item.last_byte) begin
          if (ovf_nxt) begin
            meta.status = omr_pkg::ST_TOO_LONG;
          end else begin
            len_we   = in_accept;
            tail_nxt = wslot;
            if (wslot == head_r) begin
              head_nxt    = oldest;
              meta.status = omr_pkg::ST_OVERWR;
            end
          end
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      omr_pkg::OP_READ: begin
        if (empty) begin
          meta.status = omr_pkg::ST_EMPTY;
        end else begin
          meta.message_length = 9'(old_len);
          if ((int'(in_item.byte_index) >= int'(old_len)) ||
              (int'(in_item.byte_index) >= omr_pkg::MSG_BYTES)) begin
            meta.status = omr_pkg::ST_BAD_IDX;
          end else begin
            meta.rd_ok = 1'b1;
            ram_re     = in_accept;
          end
        end
      end
      omr_pkg::OP_POP: begin
        if (empty) begin
          meta.status = omr_pkg::ST_EMPTY;
        end else begin
          head_nxt = oldest;
        end
      end
      default: begin
      end
    endcase
    meta.tail_index = 3'(tail_nxt);
    meta.is_empty   = (head_nxt == tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (in_accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_r[wslot] <= cnt_r + omr_pkg::CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/omr_out.sv -----
module omr_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  omr_pkg::meta_t     meta,
  input  logic [7:0]         ram_q,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output omr_pkg::out_item_t out_item
);

  logic               s1_v_r;
  omr_pkg::meta_t     s1_meta_r;
  logic               out_v_r;
  omr_pkg::out_item_t out_item_r;
  omr_pkg::out_item_t s1_item;
  logic               s1_adv;

  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;

  always_comb begin
    s1_item.status         = s1_meta_r.status;
    s1_item.read_data      = s1_meta_r.rd_ok ? ram_q : 8'd0;
    s1_item.message_length = s1_meta_r.message_length;
    s1_item.tail_index     = s1_meta_r.tail_index;
    s1_item.is_empty       = s1_meta_r.is_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_item_r <= s1_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/omr_checker.sv -----
`include "assert_macros.svh"

module omr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input omr_pkg::out_item_t out_item
);

  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `AST_IMPL(a_stall_backpressure, clk, rst_n, in_valid && in_stall, out_valid && out_stall)
  `AST_IMPL(a_empty_flag, clk, rst_n, out_valid && out_item.status == omr_pkg::ST_EMPTY, out_item.is_empty)
  `AST_IMPL(a_data_ok, clk, rst_n, out_valid && out_item.read_data != 8'd0, out_item.status == omr_pkg::ST_OK)
  `AST_IMPL(a_overwr_nonempty, clk, rst_n, out_valid && out_item.status == omr_pkg::ST_OVERWR, !out_item.is_empty)

endmodule

bind overwrite_oldest_message_ring_unit omr_checker u_omr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
